// File: rtl/amls_pkg.sv
// Shared types and constants for the multi-span loop sequencer.
// No dependencies; imported by amls_round and audio_multi_loop_sequencer.
`timescale 1ns / 1ps

package amls_pkg;

  localparam int MAX_SPANS = 16;
  localparam int IDX_W     = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CNT_W     = $clog2(MAX_SPANS + 1);
  localparam int SMP_W     = 32;
  localparam int CC_W      = 4;

  // Configuration register indexes.
  localparam logic [7:0] REG_CHANNEL_COUNT  = 8'd0;
  localparam logic [7:0] REG_TOTAL_SAMPLES  = 8'd1;
  localparam logic [7:0] REG_LOOP_ENABLE    = 8'd2;
  localparam logic [7:0] REG_SOURCE_IS_FILE = 8'd3;

  typedef enum logic [2:0] {
    ST_STORED,
    ST_REJECTED,
    ST_FULL,
    ST_INVALID,
    ST_NONE,
    ST_JUMP,
    ST_ENDED,
    ST_EOF_WRAP
  } status_t;

endpackage

// File: rtl/audio_multi_loop_sequencer.sv
// Top level of the multi-span loop sequencer: span table memory, control FSM,
// configuration registers and output register. Depends on amls_pkg, amls_round.
`timescale 1ns / 1ps
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser: req_type; tdata: point and offset fields
//  m_*       out        m_tvalid/m_tready  tuser: status; tdata: position and flags
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// An add word passes the nibble-serial remainder unit, which then hands its result
// over, then a table write and a read of entry 0 through the registered memory
// port. The read is skipped while the table stays empty, and an add with a zero
// channel count or sound length goes straight to the output step.
// A query word ends after S_QUERY, or after S_LOAD when the next span is fetched.
// One word is in work at a time; the result waits in the output register and
// stalls only the final step of the next word.
// Reset (rst, synchronous) empties the table at once; configuration is always taken.

module audio_multi_loop_sequencer
  import amls_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [0:0]   s_tuser,    // [0] req_type
  input  logic [103:0] s_tdata,    // [0] first_of_batch, [32:1] point_offset,
                                   // [64:33] point_length, [96:65] current_offset
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [2:0]   m_tuser,    // [2:0] status
  output logic [39:0]  m_tdata,    // [31:0] new_position, [32] position_valid,
                                   // [33] looping_disabled
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_RD0,
    S_QUERY,
    S_LOAD,
    S_FINISH
  } state_t;

  state_t           state;

  logic [CC_W-1:0]  channel_count;
  logic [SMP_W-1:0] total_samples;
  logic             loop_enable;
  logic             source_is_file;

  logic [CNT_W-1:0] span_count;
  logic [IDX_W-1:0] span_index;
  logic [SMP_W-1:0] active_start;
  logic [SMP_W-1:0] active_length;

  logic [SMP_W-1:0] cur_offset;
  logic             load_report;

  status_t          res_status;
  logic [SMP_W-1:0] res_pos;
  logic             res_valid;
  logic             res_dis;

  // Span table: each entry holds {length, start}.
  logic [2*SMP_W-1:0] span_mem [MAX_SPANS];
  logic [2*SMP_W-1:0] mem_rdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [2*SMP_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;

  logic               rnd_start;
  logic               rnd_done;
  logic [SMP_W:0]     rnd_off;
  logic [SMP_W:0]     rnd_len;

  logic               in_accept;
  logic               add_invalid;
  logic               off_past;
  logic               len_zero;
  logic               tbl_full;
  logic [SMP_W-1:0]   room;
  logic [SMP_W-1:0]   len_clamped;
  logic [CNT_W-1:0]   count_after;
  logic [SMP_W:0]     active_end;
  logic               span_hit;
  logic [CNT_W-1:0]   idx_plus1;
  logic               at_last;
  logic               before_last;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign add_invalid = (channel_count == '0) || (total_samples == '0);
  assign rnd_start = in_accept && !s_tuser[0] && !add_invalid;

  amls_round u_round (
    .clk     (clk),
    .rst     (rst),
    .start   (rnd_start),
    .granule (channel_count),
    .val_a   (s_tdata[32:1]),
    .val_b   (s_tdata[64:33]),
    .done    (rnd_done),
    .res_a   (rnd_off),
    .res_b   (rnd_len)
  );

  // Add decision, used in S_ADD.
  always_comb begin
    off_past    = rnd_off >= {1'b0, total_samples};
    len_zero    = (rnd_len == '0);
    tbl_full    = span_count >= CNT_W'(MAX_SPANS);
    room        = total_samples - rnd_off[SMP_W-1:0];
    len_clamped = (rnd_len > {1'b0, room}) ? room : rnd_len[SMP_W-1:0];
    mem_we      = (state == S_ADD) && !off_past && !len_zero && !tbl_full;
    mem_waddr   = span_count[IDX_W-1:0];
    mem_wdata   = {len_clamped, rnd_off[SMP_W-1:0]};
    count_after = span_count + CNT_W'(mem_we);
  end

  // Query decision, used in S_QUERY.
  always_comb begin
    active_end  = {1'b0, active_start} + {1'b0, active_length};
    span_hit    = (active_length != '0) && ({1'b0, cur_offset} == active_end);
    idx_plus1   = CNT_W'(span_index) + CNT_W'(1);
    at_last     = (idx_plus1 == span_count);
    before_last = (idx_plus1 < span_count);
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state == S_RD0) begin
      mem_re = 1'b1;
    end else if (state == S_QUERY && span_hit && span_count != '0) begin
      if (at_last) begin
        mem_re = loop_enable;
      end else if (before_last) begin
        mem_re    = 1'b1;
        mem_raddr = idx_plus1[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      span_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= span_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count  <= CC_W'(2);
      total_samples  <= '0;
      loop_enable    <= 1'b1;
      source_is_file <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANNEL_COUNT:  channel_count  <= cfg_data[CC_W-1:0];
        REG_TOTAL_SAMPLES:  total_samples  <= cfg_data;
        REG_LOOP_ENABLE:    loop_enable    <= cfg_data[0];
        REG_SOURCE_IS_FILE: source_is_file <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      span_count    <= '0;
      span_index    <= '0;
      active_start  <= '0;
      active_length <= '0;
      m_tvalid      <= 1'b0;
      load_report   <= 1'b0;
    end else begin
      // In S_FINISH the output register is reloaded below instead.
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            cur_offset <= s_tdata[96:65];
            res_pos    <= '0;
            res_valid  <= 1'b0;
            res_dis    <= 1'b0;
            if (s_tuser[0]) begin
              state <= S_QUERY;
            end else begin
              if (s_tdata[0]) begin
                span_index <= '0;
              end
              if (add_invalid) begin
                res_status <= ST_INVALID;
                state      <= S_FINISH;
              end else begin
                state <= S_ROUND;
              end
            end
          end
        end
        S_ROUND: begin
          if (rnd_done) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (off_past || len_zero) begin
            res_status <= ST_REJECTED;
          end else if (tbl_full) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_STORED;
          end
          span_count  <= count_after;
          load_report <= 1'b0;
          state       <= (count_after != '0) ? S_RD0 : S_FINISH;
        end
        S_RD0: begin
          state <= S_LOAD;
        end
        S_QUERY: begin
          state <= S_FINISH;
          if (span_hit) begin
            if (span_count == '0) begin
              res_status <= ST_ENDED;
              res_pos    <= total_samples;
              res_valid  <= !source_is_file;
            end else if (at_last) begin
              span_index <= '0;
              if (loop_enable) begin
                load_report <= 1'b1;
                state       <= S_LOAD;
              end else begin
                res_status <= ST_ENDED;
                res_pos    <= total_samples;
                res_valid  <= !source_is_file;
                res_dis    <= 1'b1;
              end
            end else if (before_last) begin
              span_index  <= idx_plus1[IDX_W-1:0];
              load_report <= 1'b1;
              state       <= S_LOAD;
            end else begin
              // Index beyond the table: the active span stays as it is.
              res_status <= ST_JUMP;
              res_pos    <= active_start;
              res_valid  <= 1'b1;
            end
          end else if (cur_offset >= total_samples) begin
            res_status <= ST_EOF_WRAP;
            res_valid  <= 1'b1;
          end else begin
            res_status <= ST_NONE;
          end
        end
        S_LOAD: begin
          active_start  <= mem_rdata[SMP_W-1:0];
          active_length <= mem_rdata[2*SMP_W-1:SMP_W];
          if (load_report) begin
            res_status <= ST_JUMP;
            res_pos    <= mem_rdata[SMP_W-1:0];
            res_valid  <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {6'b0, res_dis, res_valid, res_pos};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    span_count <= CNT_W'(MAX_SPANS))
    else $error("span count beyond table depth");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (span_count == '0) ? (span_index == '0) : (CNT_W'(span_index) < span_count))
    else $error("span index outside the filled table");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (span_count < CNT_W'(MAX_SPANS)))
    else $error("table write with no room");

  a_round_done: assert property (@(posedge clk) disable iff (rst)
    rnd_done |-> (state == S_ROUND))
    else $error("rounding result outside the rounding step");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (span_count == $past(span_count) + CNT_W'(1)))
    else $error("span count did not follow the table write");

endmodule

// File: rtl/amls_round.sv
// Rounds two sample counts up to a multiple of the channel count.
// The remainder is found four bits a cycle, most significant first. Uses amls_pkg.
`timescale 1ns / 1ps

module amls_round
  import amls_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CC_W-1:0]  granule,
  input  logic [SMP_W-1:0] val_a,
  input  logic [SMP_W-1:0] val_b,
  output logic             done,
  output logic [SMP_W:0]   res_a,
  output logic [SMP_W:0]   res_b
);

  localparam int V_W    = SMP_W + 1;
  localparam int STEPS  = (V_W + 3) / 4;
  localparam int SH_W   = STEPS * 4;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy;
  logic              last;
  logic [STEP_W-1:0] step;
  logic [CC_W-1:0]   g;
  logic [V_W-1:0]    va;
  logic [V_W-1:0]    vb;
  logic [SH_W-1:0]   sha;
  logic [SH_W-1:0]   shb;
  logic [CC_W-1:0]   rema;
  logic [CC_W-1:0]   remb;
  logic [V_W-1:0]    bias_a;
  logic [V_W-1:0]    bias_b;

  // Four bits of long division by a granule below 16; the partial remainder
  // stays under twice the granule, so one compare and subtract per bit.
  function automatic logic [CC_W-1:0] rem_nib(input logic [CC_W-1:0] r,
                                              input logic [3:0] nib,
                                              input logic [CC_W-1:0] d);
    logic [CC_W:0]   t;
    logic [CC_W-1:0] acc;
    acc = r;
    for (int i = 3; i >= 0; i--) begin
      t = {acc, nib[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      acc = t[CC_W-1:0];
    end
    return acc;
  endfunction

  assign bias_a = {1'b0, val_a} + V_W'(granule) - V_W'(1);
  assign bias_b = {1'b0, val_b} + V_W'(granule) - V_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      last <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        g    <= granule;
        va   <= bias_a;
        vb   <= bias_b;
        sha  <= SH_W'(bias_a);
        shb  <= SH_W'(bias_b);
        rema <= '0;
        remb <= '0;
      end else if (busy) begin
        rema <= rem_nib(rema, sha[SH_W-1 -: 4], g);
        remb <= rem_nib(remb, shb[SH_W-1 -: 4], g);
        sha  <= {sha[SH_W-5:0], 4'b0};
        shb  <= {shb[SH_W-5:0], 4'b0};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          last <= 1'b1;
        end
      end else if (last) begin
        last  <= 1'b0;
        done  <= 1'b1;
        res_a <= va - V_W'(rema);
        res_b <= vb - V_W'(remb);
      end
    end
  end

endmodule
